// ===== sv/rtor_pkg.sv =====
// ----------------------------------------------------------------------------
// Region table package
// Shared constants and types for the region table overlap registry.
// ----------------------------------------------------------------------------
package rtor_pkg;

    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_FREEZE   = 1'b1;

    // Bytes in one entry's 24-byte record.
    localparam int ENTRY_BYTES = 24;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_HREAD = 6'b001000,
        ST_HASH  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Control from the sequencer to the hash unit.
    typedef struct packed {
        logic init;
        logic step;
    } hash_ctl_t;

endpackage

// ===== sv/rtor_hash.sv =====
// ----------------------------------------------------------------------------
// FNV-1a style 64-bit byte hasher
// Folds one byte per step into a running 64-bit FNV-1a style hash (nonstandard basis).
// ----------------------------------------------------------------------------
module rtor_hash
    import rtor_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hash_ctl_t   ctl,
    input  logic [7:0]  data,
    output logic [63:0] hash
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] mixed;

    assign mixed = hash_reg ^ {56'd0, data};

    always_comb
    begin
        hash_next = hash_reg;
        if (ctl.init)
        begin
            hash_next = FNV_BASIS;
        end
        else if (ctl.step)
        begin
            // The prime is 2^40 + 0x1B3, so the product modulo 2^64 is a sum of shifts.
            hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                      + (mixed << 4) + (mixed << 1) + mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

// ===== sv/region_table_overlap_registry.sv =====
// ----------------------------------------------------------------------------
// Region table overlap registry
// Bounded region table with overlap and tag checks and an FNV-1a style freeze digest.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in/out     start, busy (out), kind, region_*, manifest_value
// result    out        done, accepted, entry_count, byte_sum, table_hash
// config    in         cfg_we, cfg_wdata (allowed_flag_mask)
//
// A register item scans the held entries in turn through the single table read
// port, stops at the first conflict, else writes the entry; then shows the result.
// A freeze item hashes each entry in 24 byte steps of the hash multiplier, with a
// read state before each entry but the first. Up-front rejections skip to done.
// Reset clears count, total, lock and digest; table contents need no clear.
// The result is shown on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module region_table_overlap_registry
    import rtor_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [63:0] region_base,
    input  logic [63:0] region_size,
    input  logic [31:0] region_tag,
    input  logic [31:0] region_flags,
    input  logic [63:0] manifest_value,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic        accepted,
    output logic [4:0]  entry_count,
    output logic [63:0] byte_sum,
    output logic [63:0] table_hash
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [191:0] mem [MAX_REGIONS];
    logic [191:0] rd_reg;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0]  byte_reg, byte_next;
    logic [63:0] total_reg, total_next;
    logic        locked_reg, locked_next;
    logic [63:0] digest_reg, digest_next;
    logic [63:0] manifest_reg, manifest_next;
    logic [31:0] mask_reg;
    logic        ok_reg, ok_next;
    logic        kind_reg;
    logic [63:0] base_reg, size_reg, end_reg;
    logic [31:0] tag_reg, flags_reg;
    logic [63:0] man_in_reg;

    hash_ctl_t   hctl;
    logic [7:0]  hbyte;
    logic [63:0] hash;
    logic        mem_we;
    logic [IW-1:0] rd_addr;

    logic        pre_ok;
    logic [64:0] end_wide, tot_wide;
    logic [63:0] ob, oe;
    logic        conflict;

    assign end_wide = {1'b0, region_base} + {1'b0, region_size};
    assign tot_wide = {1'b0, total_reg} + {1'b0, region_size};

    always_comb
    begin
        if (kind == KIND_REGISTER)
        begin
            pre_ok = !locked_reg && (count_reg < CW'(MAX_REGIONS))
                && (region_base != 64'd0) && (region_size != 64'd0)
                && (region_tag != 32'd0) && ((region_flags & ~mask_reg) == 32'd0)
                && !end_wide[64] && (end_wide[63:0] != 64'd0) && !tot_wide[64];
        end
        else
        begin
            pre_ok = !locked_reg && (count_reg != '0) && (manifest_value != 64'd0);
        end
    end

    assign ob = rd_reg[191:128];
    assign oe = rd_reg[191:128] + rd_reg[127:64];
    assign conflict = ((base_reg < oe) && (ob < end_reg)) || (rd_reg[63:32] == tag_reg);

    // Record layout: base, size, tag, flags, hashed little-endian in that order.
    always_comb
    begin
        hbyte = 8'd0;
        if (byte_reg < 5'd8)
        begin
            hbyte = rd_reg[128 + 8*byte_reg[2:0] +: 8];
        end
        else if (byte_reg < 5'd16)
        begin
            hbyte = rd_reg[64 + 8*byte_reg[2:0] +: 8];
        end
        else if (byte_reg < 5'd20)
        begin
            hbyte = rd_reg[32 + 8*byte_reg[1:0] +: 8];
        end
        else
        begin
            hbyte = rd_reg[8*byte_reg[1:0] +: 8];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        byte_next     = byte_reg;
        total_next    = total_reg;
        locked_next   = locked_reg;
        digest_next   = digest_reg;
        manifest_next = manifest_reg;
        ok_next       = ok_reg;
        hctl          = '0;
        mem_we        = 1'b0;
        rd_addr       = idx_reg[IW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (start)
                begin
                    idx_next = '0;
                    byte_next = '0;
                    hctl.init = 1'b1;
                    ok_next = pre_ok;
                    if (!pre_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (kind == KIND_REGISTER)
                    begin
                        state_next = (count_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_SCAN:
            begin
                // rd_reg holds entry idx_reg; fetch the next one.
                rd_addr = IW'(idx_reg + 1'b1);
                idx_next = idx_reg + 1'b1;
                if (conflict)
                begin
                    ok_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (idx_next == count_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                count_next = count_reg + 1'b1;
                total_next = total_reg + size_reg;
                state_next = ST_DONE;
            end
            ST_HREAD:
            begin
                byte_next = '0;
                state_next = ST_HASH;
            end
            ST_HASH:
            begin
                hctl.step = 1'b1;
                byte_next = byte_reg + 5'd1;
                if (byte_reg == 5'(ENTRY_BYTES - 1))
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr = IW'(idx_reg + 1'b1);
                    state_next = (idx_next == count_reg) ? ST_DONE : ST_HREAD;
                end
            end
            ST_DONE:
            begin
                if (kind_reg == KIND_FREEZE && ok_reg)
                begin
                    digest_next = hash;
                    manifest_next = man_in_reg;
                    locked_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IW-1:0]] <= {base_reg, size_reg, tag_reg, flags_reg};
        end
        rd_reg <= mem[rd_addr];
        if (state_reg == ST_IDLE && start)
        begin
            kind_reg   <= kind;
            base_reg   <= region_base;
            size_reg   <= region_size;
            end_reg    <= end_wide[63:0];
            tag_reg    <= region_tag;
            flags_reg  <= region_flags;
            man_in_reg <= manifest_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            byte_reg     <= '0;
            total_reg    <= '0;
            locked_reg   <= 1'b0;
            digest_reg   <= '0;
            manifest_reg <= '0;
            ok_reg       <= 1'b0;
            mask_reg     <= 32'd1;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            byte_reg     <= byte_next;
            total_reg    <= total_next;
            locked_reg   <= locked_next;
            digest_reg   <= digest_next;
            manifest_reg <= manifest_next;
            ok_reg       <= ok_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    rtor_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hctl),
        .data  (hbyte),
        .hash  (hash)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign accepted    = ok_reg;
    assign entry_count = 5'(count_reg);
    assign byte_sum    = total_reg;
    assign table_hash  = (state_reg == ST_DONE && kind_reg == KIND_FREEZE && ok_reg)
                         ? hash : digest_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS)) else $error("count over table size");
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(locked_reg) |-> locked_reg) else $error("lock released");
    a_no_grow_locked: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |=> $stable(count_reg)) else $error("table grew while frozen");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result longer than one cycle");

endmodule

// ===== test/region_table_overlap_registry_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region table overlap registry testbench
// Sends register and freeze items with random gaps, predicts each result with
// a behavioral model of the region table and compares every result field.
// No phase clears the table state; the table starts empty once, so phases
// after a freeze exercise the locked behavior.
// ----------------------------------------------------------------------------
module region_table_overlap_registry_tb
    import rtor_pkg::*;
();

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [63:0] region_base;
    logic [63:0] region_size;
    logic [31:0] region_tag;
    logic [31:0] region_flags;
    logic [63:0] manifest_value;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        done;
    logic        accepted;
    logic [4:0]  entry_count;
    logic [63:0] byte_sum;
    logic [63:0] table_hash;

    typedef struct packed {
        logic        ok;
        logic [4:0]  count;
        logic [63:0] total;
        logic [63:0] digest;
    } outcome_t;

    // Model state.
    logic [63:0] tbl_base [TABLE_DEPTH];
    logic [63:0] tbl_size [TABLE_DEPTH];
    logic [31:0] tbl_tag [TABLE_DEPTH];
    logic [31:0] tbl_flags [TABLE_DEPTH];
    int          tbl_count;
    logic [63:0] tbl_total;
    logic        tbl_locked;
    logic [63:0] tbl_digest;
    logic [31:0] flag_mask;

    outcome_t pending_outcomes[$];
    int       error_count;
    int       idle_cycles;

    region_table_overlap_registry dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .region_base(region_base), .region_size(region_size),
        .region_tag(region_tag), .region_flags(region_flags),
        .manifest_value(manifest_value), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .accepted(accepted), .entry_count(entry_count),
        .byte_sum(byte_sum), .table_hash(table_hash)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] fnv_bytes(logic [63:0] h, logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
        begin
            h = h ^ ((v >> (8 * i)) & 64'hFF);
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic table_admits(logic [63:0] b, logic [63:0] s,
                                          logic [31:0] t, logic [31:0] f);
        logic [63:0] last;
        if (tbl_locked || tbl_count >= TABLE_DEPTH) return 1'b0;
        if (b == 0 || s == 0 || t == 0) return 1'b0;
        if ((f & ~flag_mask) != 0) return 1'b0;
        if (s > ~b || s > ~tbl_total) return 1'b0;
        last = b + s;
        for (int i = 0; i < tbl_count; i++)
            if ((b < tbl_base[i] + tbl_size[i] && tbl_base[i] < last) || tbl_tag[i] == t)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic outcome_t apply_item(logic k, logic [63:0] b, logic [63:0] s,
                                            logic [31:0] t, logic [31:0] f,
                                            logic [63:0] m);
        outcome_t o;
        logic [63:0] h;
        o.ok = 1'b0;
        if (k == KIND_REGISTER)
        begin
            if (table_admits(b, s, t, f))
            begin
                tbl_base[tbl_count] = b;
                tbl_size[tbl_count] = s;
                tbl_tag[tbl_count] = t;
                tbl_flags[tbl_count] = f;
                tbl_count++;
                tbl_total += s;
                o.ok = 1'b1;
            end
        end
        else if (!tbl_locked && tbl_count != 0 && m != 0)
        begin
            h = FNV_BASIS;
            for (int i = 0; i < tbl_count; i++)
            begin
                h = fnv_bytes(h, tbl_base[i], 8);
                h = fnv_bytes(h, tbl_size[i], 8);
                h = fnv_bytes(h, {32'd0, tbl_tag[i]}, 4);
                h = fnv_bytes(h, {32'd0, tbl_flags[i]}, 4);
            end
            tbl_digest = h;
            tbl_locked = 1'b1;
            o.ok = 1'b1;
        end
        o.count = tbl_count[4:0];
        o.total = tbl_total;
        o.digest = tbl_digest;
        return o;
    endfunction

    // Start stays high until the next item or a drain lowers it, so that it
    // never takes two assignments in one time step.
    task automatic send_item(logic k, logic [63:0] b, logic [63:0] s,
                             logic [31:0] t, logic [31:0] f, logic [63:0] m);
        int   gap;
        logic ready;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        region_base <= b;
        region_size <= s;
        region_tag <= t;
        region_flags <= f;
        manifest_value <= m;
        // Busy only changes at a rising edge, so its value at the falling
        // edge tells whether the next rising edge takes the item.
        ready = 1'b0;
        while (!ready)
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end
        pending_outcomes.push_back(apply_item(k, b, s, t, f, m));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mask(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        flag_mask = v;
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // Registers regions in random slots; they may overlap or share tags.
    task automatic fill_table(int n, logic [31:0] tag_seed);
        logic [63:0] slot;
        for (int i = 0; i < n; i++)
        begin
            slot = {8'($urandom_range(1, 255)), 56'd0};
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_REGISTER, rand64(), rand64(), $urandom,
                          $urandom, rand64());
            else
                send_item(KIND_REGISTER, slot + 64'($urandom_range(0, 255)),
                          ($urandom_range(0, 255) == 0 ? rand64() >> 8 :
                           {32'd0, $urandom}) | 64'd1,
                          $urandom_range(0, 7) == 0 ? tag_seed : tag_seed + 32'(i),
                          $urandom & flag_mask, rand64());
        end
    endtask

    // Reset is applied once, so a frozen table stays frozen; the directed part
    // covers the empty table and the random part then exercises a locked one
    // after an extended unlocked phase.
    task automatic test_directed;
        send_item(KIND_FREEZE, 0, 0, 0, 0, 64'd5);              // empty freeze
        send_item(KIND_REGISTER, 0, 64'd16, 32'd1, 0, 0);       // zero base
        send_item(KIND_REGISTER, 64'd16, 0, 32'd1, 0, 0);       // zero size
        send_item(KIND_REGISTER, 64'd16, 64'd16, 0, 0, 0);      // zero tag
        send_item(KIND_REGISTER, 64'd16, 64'd16, 32'd1, 32'd2, 0); // bad flag
        send_item(KIND_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 32'd2, 0, 0);
        send_item(KIND_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 64'hF, 32'd2, 1, 0);
        send_item(KIND_REGISTER, 64'd16, 64'd16, 32'd3, 1, 0);
        send_item(KIND_REGISTER, 64'd31, 64'd1, 32'd4, 0, 0);   // overlap
        send_item(KIND_REGISTER, 64'd1, 64'd15, 32'd4, 0, 0);   // touches, ok
        send_item(KIND_REGISTER, 64'd32, 64'd4, 32'd3, 0, 0);   // repeated tag
        send_item(KIND_REGISTER, 64'h100, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF,
                  0, 0);                                         // end wraps
        send_item(KIND_FREEZE, 0, 0, 0, 0, 0);                   // zero manifest
        drain();
        write_mask(32'hFFFF_FFFF);
        send_item(KIND_REGISTER, 64'h40, 64'h8, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        drain();
        write_mask(32'h0);
        send_item(KIND_REGISTER, 64'h50, 64'h8, 32'd9, 32'd1, 0);
        send_item(KIND_REGISTER, 64'h50, 64'h8, 32'd9, 32'd0, 0);
    endtask

    task automatic test_random_unlocked;
        for (int round = 0; round < 40; round++)
        begin
            drain();
            write_mask($urandom_range(0, 2) == 0 ? $urandom : 32'hFFFF_FFFF);
            fill_table(20, $urandom | 1);
        end
    endtask

    task automatic test_freeze_and_locked;
        drain();
        write_mask($urandom);
        send_item(KIND_FREEZE, rand64(), rand64(), $urandom, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_FREEZE, 0, 0, 0, 0, rand64() | 1);        // second freeze
        for (int i = 0; i < 980; i++)
            send_item(1'($urandom_range(0, 1)), rand64(), rand64(), $urandom,
                      $urandom, rand64());
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                error_count++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (accepted !== exp_o.ok || entry_count !== exp_o.count ||
                    byte_sum !== exp_o.total || table_hash !== exp_o.digest)
                begin
                    $display("%0t: expected ok=%0b n=%0d tot=%h dig=%h", $time,
                             exp_o.ok, exp_o.count, exp_o.total, exp_o.digest);
                    $display("%0t: actual   ok=%0b n=%0d tot=%h dig=%h", $time,
                             accepted, entry_count, byte_sum, table_hash);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("region_table_overlap_registry_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        tbl_count = 0;
        tbl_total = 0;
        tbl_locked = 1'b0;
        tbl_digest = 0;
        flag_mask = 32'd1;
        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        region_base = 0;
        region_size = 0;
        region_tag = 0;
        region_flags = 0;
        manifest_value = 0;
        cfg_we = 1'b0;
        cfg_wdata = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_unlocked();
        test_freeze_and_locked();
        drain();
        if (error_count == 0)
            $display("region_table_overlap_registry_tb OK");
        else
            $display("region_table_overlap_registry_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/rtor_pkg.sv
sv/rtor_hash.sv
sv/region_table_overlap_registry.sv
test/region_table_overlap_registry_tb.sv
